// ===== design/vbd_pkg.sv =====
package vbd_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_START   = 2'd1,
    REQ_BIT     = 2'd2,
    REQ_LITERAL = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_STARVED     = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_NOT_STARTED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NORM,
    BK_WAIT,
    BK_BYTE,
    BK_MUL,
    BK_DEC,
    BK_RESP
  } back_state_e;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    req_type_e   kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  prob;
    logic [5:0]  nbits;
  } cmd_t;

  localparam logic [7:0]        RangeInit      = 8'd255;
  localparam logic signed [4:0] CreditInit     = -5'sd16;
  localparam logic [7:0]        LiteralProb    = 8'd128;
  localparam logic [5:0]        MaxLiteralBits = 6'd32;

endpackage

// ===== design/vbd_if.sv =====
interface vbd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [7:0] probability;
  logic [5:0] literal_bits;

  modport source (
    output valid, req_type, data_byte, last_byte, probability, literal_bits,
    input  ready
  );
  modport sink (
    input  valid, req_type, data_byte, last_byte, probability, literal_bits,
    output ready
  );
endinterface

interface vbd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

// ===== design/vbd_front.sv =====
module vbd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  vbd_req_if.sink       req_i,
  output vbd_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import vbd_pkg::*;

  cmd_t       cls;
  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // Classify: literal runs at fixed probability, length clamped
  always_comb begin
    cls.kind      = req_type_e'(req_i.req_type);
    cls.data_byte = req_i.data_byte;
    cls.last_byte = req_i.last_byte;
    cls.prob      = (cls.kind == REQ_LITERAL) ? LiteralProb : req_i.probability;
    if (cls.kind == REQ_BIT) begin
      cls.nbits = 6'd1;
    end else if (req_i.literal_bits > MaxLiteralBits) begin
      cls.nbits = MaxLiteralBits;
    end else begin
      cls.nbits = req_i.literal_bits;
    end
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = req_i.valid && req_i.ready;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== design/vbd_back.sv =====
module vbd_back #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vbd_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  vbd_rsp_if.source     rsp_o
);
  import vbd_pkg::*;

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  back_state_e       state_q, state_d;
  logic [7:0]        range_q, range_d;
  logic [23:0]       cw_q, cw_d;
  logic signed [4:0] credit_q, credit_d, credit_n;
  logic [PtrW-1:0]   rp_q, rp_d, wp_q, wp_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              ended_q, ended_d;
  logic              started_q, started_d;
  logic              out_valid_q, out_valid_d;

  cmd_t              cmd_q, cmd_d;
  logic [1:0]        bytes_left_q, bytes_left_d;
  logic [5:0]        bits_left_q, bits_left_d;
  logic [15:0]       acc_q, acc_d;
  logic [7:0]        split_q, split_d;
  logic [31:0]       value_q, value_d;
  status_e           res_status_q, res_status_d;
  logic [31:0]       out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;
  logic [PtrW-1:0]   snap_rp_q, snap_rp_d;
  logic [CntW-1:0]   snap_count_q, snap_count_d;
  logic [7:0]        snap_range_q, snap_range_d;
  logic [23:0]       snap_cw_q, snap_cw_d;
  logic signed [4:0] snap_credit_q, snap_credit_d;

  logic [7:0]        mem [FIFO_DEPTH];
  logic [7:0]        rd_q;
  logic              mem_we;
  logic [3:0]        sh;
  logic [7:0]        b;
  logic [15:0]       prod;
  logic              bit_one;

  function automatic logic [3:0] norm_shift(logic [7:0] r);
    logic [3:0] s;
    s = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (r[i]) s = 4'(7 - i);
    end
    return s;
  endfunction

  assign cmd_ready_o  = (state_q == BK_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.value  = out_value_q;
  assign rsp_o.status = out_status_q;

  always_comb begin
    state_d       = state_q;
    range_d       = range_q;
    cw_d          = cw_q;
    credit_d      = credit_q;
    rp_d          = rp_q;
    wp_d          = wp_q;
    count_d       = count_q;
    ended_d       = ended_q;
    started_d     = started_q;
    cmd_d         = cmd_q;
    bytes_left_d  = bytes_left_q;
    bits_left_d   = bits_left_q;
    acc_d         = acc_q;
    split_d       = split_q;
    value_d       = value_q;
    res_status_d  = res_status_q;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;
    snap_rp_d     = snap_rp_q;
    snap_count_d  = snap_count_q;
    snap_range_d  = snap_range_q;
    snap_cw_d     = snap_cw_q;
    snap_credit_d = snap_credit_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    mem_we        = 1'b0;
    sh            = norm_shift(range_q);
    credit_n      = credit_q + $signed({1'b0, sh});
    b             = 8'd0;
    prod          = {8'd0, range_q - 8'd1} * {8'd0, cmd_q.prob};
    bit_one       = (cw_q >= {split_q, 16'h0000});

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d         = cmd_i;
          snap_rp_d     = rp_q;
          snap_count_d  = count_q;
          snap_range_d  = range_q;
          snap_cw_d     = cw_q;
          snap_credit_d = credit_q;
          value_d       = 32'd0;
          res_status_d  = ST_OK;
          bytes_left_d  = 2'd3;
          acc_d         = 16'd0;
          bits_left_d   = cmd_i.nbits;
          state_d       = BK_RESP;
          case (cmd_i.kind)
            REQ_PUSH: begin
              if (count_q == CntFull) begin
                res_status_d = ST_OVERFLOW;
              end else begin
                mem_we  = 1'b1;
                wp_d    = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
                count_d = count_q + 1'b1;
                // a plain byte into an empty FIFO opens a new partition
                if (cmd_i.last_byte) begin
                  ended_d = 1'b1;
                end else if (count_q == '0) begin
                  ended_d = 1'b0;
                end
              end
            end
            REQ_START: begin
              state_d = BK_WAIT;
            end
            REQ_BIT, REQ_LITERAL: begin
              if (!started_q) begin
                res_status_d = ST_NOT_STARTED;
              end else if (cmd_i.nbits != 6'd0) begin
                state_d = BK_NORM;
              end
            end
            default: begin
              state_d = BK_RESP;
            end
          endcase
        end
      end

      BK_NORM: begin
        range_d  = 8'(range_q << sh);
        cw_d     = 24'(cw_q << sh);
        credit_d = credit_n;
        if (!credit_n[4]) begin
          bytes_left_d = 2'd2;
          acc_d        = 16'd0;
          state_d      = BK_WAIT;
        end else begin
          state_d = BK_MUL;
        end
      end

      // wait state for the registered FIFO read at the current read pointer
      BK_WAIT: begin
        state_d = BK_BYTE;
      end

      BK_BYTE: begin
        if (count_q == '0 && !ended_q) begin
          // starved: roll the whole transaction back
          range_d      = snap_range_q;
          cw_d         = snap_cw_q;
          credit_d     = snap_credit_q;
          rp_d         = snap_rp_q;
          count_d      = snap_count_q;
          value_d      = 32'd0;
          res_status_d = ST_STARVED;
          state_d      = BK_RESP;
        end else begin
          if (count_q != '0) begin
            b       = rd_q;
            rp_d    = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
            count_d = count_q - 1'b1;
          end
          acc_d = {acc_q[7:0], b};
          if (bytes_left_q == 2'd1) begin
            if (cmd_q.kind == REQ_START) begin
              cw_d         = {acc_q, b};
              range_d      = RangeInit;
              credit_d     = CreditInit;
              started_d    = 1'b1;
              res_status_d = ST_OK;
              state_d      = BK_RESP;
            end else begin
              cw_d     = cw_q | 24'({8'd0, acc_q[7:0], b} << credit_q[2:0]);
              // drop the credit by 16
              credit_d = credit_q + CreditInit;
              state_d  = BK_MUL;
            end
          end else begin
            bytes_left_d = bytes_left_q - 2'd1;
            state_d      = BK_WAIT;
          end
        end
      end

      BK_MUL: begin
        split_d = prod[15:8] + 8'd1;
        state_d = BK_DEC;
      end

      BK_DEC: begin
        if (bit_one) begin
          range_d = range_q - split_q;
          cw_d    = cw_q - {split_q, 16'h0000};
        end else begin
          range_d = split_q;
        end
        value_d     = {value_q[30:0], bit_one};
        bits_left_d = bits_left_q - 6'd1;
        if (bits_left_q == 6'd1) begin
          res_status_d = ST_OK;
          state_d      = BK_RESP;
        end else begin
          state_d = BK_NORM;
        end
      end

      BK_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_value_d  = value_q;
          out_status_d = res_status_q;
          state_d      = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      range_q     <= RangeInit;
      cw_q        <= 24'd0;
      credit_q    <= CreditInit;
      rp_q        <= '0;
      wp_q        <= '0;
      count_q     <= '0;
      ended_q     <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      range_q     <= range_d;
      cw_q        <= cw_d;
      credit_q    <= credit_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      count_q     <= count_d;
      ended_q     <= ended_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    bytes_left_q  <= bytes_left_d;
    bits_left_q   <= bits_left_d;
    acc_q         <= acc_d;
    split_q       <= split_d;
    value_q       <= value_d;
    res_status_q  <= res_status_d;
    out_value_q   <= out_value_d;
    out_status_q  <= out_status_d;
    snap_rp_q     <= snap_rp_d;
    snap_count_q  <= snap_count_d;
    snap_range_q  <= snap_range_d;
    snap_cw_q     <= snap_cw_d;
    snap_credit_q <= snap_credit_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= cmd_i.data_byte;
    end
    rd_q <= mem[rp_q];
  end

endmodule

// ===== design/vp8_bool_decoder.sv =====
// Boolean range decoder with a compressed-byte FIFO.
// req_i carries one request per transaction: push a byte (optionally marked as
// the partition's last), start a partition, decode one bit at a given
// probability, or decode a literal of up to 32 bits. rsp_o returns exactly one
// transaction per request, in order, with the decoded value and a status.
// A two-entry queue in the front end takes requests while the back end works
// and while a response waits in the output register.
// The back end serves one request at a time: a push or a rejected request goes
// straight to the response register; a start reads three bytes, each through a
// wait and a byte state; a bit normalizes, refills two bytes when the credit
// turns nonnegative, then multiplies and compares; a literal repeats the bit
// step per bit. The pace is set by the single bit-step sequencer (normalize,
// multiply, compare) and the registered FIFO read port.
// Reset clears the queue, the FIFO pointers and the decode state (range 255,
// credit -16, not started); FIFO contents are not cleared.
// If the receiver stalls, the response holds in the output register, the back
// end finishes at most one more request and then waits; the queue fills and
// req_i.ready drops.
module vp8_bool_decoder #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vbd_req_if.sink   req_i,
  vbd_rsp_if.source rsp_o
);
  import vbd_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  vbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  vbd_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .rsp_o       (rsp_o)
  );

  a_err_value_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |-> (rsp_o.value == 32'd0))
    else $error("non-ok response carries a nonzero value");

  a_queue_presents : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && !cmd_valid |=> cmd_valid)
    else $error("accepted request not presented to back end");

  a_back_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("back end took a second request while busy");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import vbd_pkg::*;

  localparam int FifoDepth  = 16;
  localparam int ItemTarget = 1150;
  localparam int DrainAt    = 700;   // sender waits for all responses here
  localparam int HoldAt     = 150;   // receiver starts its long stall here
  localparam int HoldCycles = 400;
  localparam int IdleLimit  = 4000;
  localparam int TailCycles = 60;

  typedef struct packed {
    req_type_e  kind;
    logic [7:0] data;
    logic       last;
    logic [7:0] prob;
    logic [5:0] nbits;
  } req_item_t;

  typedef struct packed {
    logic [31:0] value;
    status_e     status;
  } dec_result_t;

  typedef struct packed {
    logic [15:0][7:0] fifo;
    logic [7:0]       rng;
    logic [23:0]      win;
    int               credit;
    logic [4:0]       cnt;
    logic [3:0]       rd;
    logic [3:0]       wr;
    logic             ended;
    logic             started;
  } dec_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  vbd_req_if req_if ();
  vbd_rsp_if rsp_if ();

  vp8_bool_decoder #(.FIFO_DEPTH(FifoDepth)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  req_item_t   pending_reqs[$];
  dec_result_t expected_rsps[$];
  dec_state_t  dec;

  int  errors = 0;
  int  reqs_sent = 0;
  int  rsps_seen = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;
  bit  drain_wait = 1'b0;
  dec_result_t want;

  // ---------------------------------------------------------------------------
  // Decoder state tracking
  // ---------------------------------------------------------------------------
  function automatic bit pull_byte(output logic [7:0] b);
    b = 8'h00;
    if (dec.cnt != 5'd0) begin
      b       = dec.fifo[dec.rd];
      dec.rd  = dec.rd + 4'd1;
      dec.cnt = dec.cnt - 5'd1;
      return 1'b1;
    end
    // past the end mark missing bytes read as zero
    return dec.ended;
  endfunction

  function automatic bit step_bit(input logic [7:0] prob, output logic one);
    logic [31:0] hi;
    logic [31:0] cw;
    logic [31:0] split;
    logic [7:0]  b0;
    logic [7:0]  b1;
    int          shift;
    hi    = {24'd0, dec.rng};
    cw    = {8'd0, dec.win};
    shift = 0;
    one   = 1'b0;
    while (shift < 8 && hi < 32'd128) begin
      hi = hi << 1;
      shift++;
    end
    if (hi == 32'd0) shift = 8;
    cw = (cw << shift) & 32'h00FF_FFFF;
    dec.credit += shift;
    if (dec.credit >= 0) begin
      if (!pull_byte(b0)) return 1'b0;
      if (!pull_byte(b1)) return 1'b0;
      cw = (cw | ({16'd0, b0, b1} << (dec.credit & 7))) & 32'h00FF_FFFF;
      dec.credit -= 16;
    end
    split = 32'd1 + (((hi - 32'd1) * {24'd0, prob}) >> 8);
    if (cw >= (split << 16)) begin
      one     = 1'b1;
      dec.rng = 8'(hi - split);
      dec.win = 24'(cw - (split << 16));
    end else begin
      dec.rng = split[7:0];
      dec.win = cw[23:0];
    end
    return 1'b1;
  endfunction

  function automatic dec_result_t decode_request(input req_item_t it);
    dec_result_t r;
    dec_state_t  saved;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic        one;
    bit          ok;
    int          n;
    saved    = dec;
    r.value  = 32'd0;
    r.status = ST_OK;
    case (it.kind)
      REQ_PUSH: begin
        if (dec.cnt >= FifoDepth) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (it.last) dec.ended = 1'b1;
          else if (dec.cnt == 5'd0) dec.ended = 1'b0;
          dec.fifo[dec.wr] = it.data;
          dec.wr  = dec.wr + 4'd1;
          dec.cnt = dec.cnt + 5'd1;
        end
      end
      REQ_START: begin
        ok = pull_byte(b0);
        if (ok) ok = pull_byte(b1);
        if (ok) ok = pull_byte(b2);
        if (ok) begin
          dec.rng     = RangeInit;
          dec.credit  = CreditInit;
          dec.win     = {b0, b1, b2};
          dec.started = 1'b1;
        end else begin
          dec      = saved;
          r.status = ST_STARVED;
        end
      end
      default: begin
        if (!dec.started) begin
          r.status = ST_NOT_STARTED;
        end else if (it.kind == REQ_BIT) begin
          if (step_bit(it.prob, one)) begin
            r.value = {31'd0, one};
          end else begin
            dec      = saved;
            r.status = ST_STARVED;
          end
        end else begin
          n = (it.nbits > MaxLiteralBits) ? int'(MaxLiteralBits) : int'(it.nbits);
          for (int i = 0; i < n; i++) begin
            if (!step_bit(LiteralProb, one)) begin
              dec      = saved;
              r.status = ST_STARVED;
              r.value  = 32'd0;
              break;
            end
            r.value = {r.value[30:0], one};
          end
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_req(input req_type_e k, input logic [7:0] d, input logic l,
                         input logic [7:0] p, input logic [5:0] n);
    req_item_t it;
    it.kind  = k;
    it.data  = d;
    it.last  = l;
    it.prob  = p;
    it.nbits = n;
    pending_reqs.push_back(it);
  endtask

  task automatic push_rand(input logic l);
    add_req(REQ_PUSH, 8'($urandom), l, 8'($urandom), 6'($urandom));
  endtask

  task automatic decode_rand();
    logic [7:0] p;
    logic [5:0] n;
    int         pick;
    pick = $urandom_range(0, 19);
    p = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    if (pick < 12) begin
      add_req(REQ_BIT, 8'($urandom), 1'($urandom), p, 6'($urandom));
    end else begin
      if (pick < 17) n = 6'($urandom_range(1, 12));
      else if (pick < 19) n = 6'($urandom_range(13, 32));
      else n = 6'($urandom);
      add_req(REQ_LITERAL, 8'($urandom), 1'($urandom), p, n);
    end
  endtask

  initial begin
    int len;
    int steps;
    int pick;
    bit first;

    rst_ni <= 1'b0;
    dec        = '0;
    dec.rng    = RangeInit;
    dec.credit = CreditInit;

    // nothing started, nothing buffered
    add_req(REQ_BIT,     8'h00, 1'b0, 8'd128, 6'd0);
    add_req(REQ_LITERAL, 8'h00, 1'b0, 8'd0,   6'd0);
    add_req(REQ_START,   8'h00, 1'b0, 8'd0,   6'd0);
    add_req(REQ_PUSH,    8'hFF, 1'b0, 8'd0,   6'd0);
    add_req(REQ_PUSH,    8'h00, 1'b0, 8'd0,   6'd0);
    add_req(REQ_PUSH,    8'hA5, 1'b0, 8'd0,   6'd0);
    add_req(REQ_START,   8'h00, 1'b0, 8'd0,   6'd0);
    add_req(REQ_BIT,     8'h00, 1'b0, 8'd0,   6'd0);
    add_req(REQ_BIT,     8'h00, 1'b0, 8'd255, 6'd0);
    add_req(REQ_LITERAL, 8'h00, 1'b0, 8'd0,   6'd0);
    // oversized literal on an empty FIFO: clamp, then starve and roll back
    add_req(REQ_LITERAL, 8'h00, 1'b0, 8'd0,   6'd63);
    add_req(REQ_PUSH,    8'h5A, 1'b1, 8'd0,   6'd0);
    add_req(REQ_LITERAL, 8'h00, 1'b0, 8'd0,   6'd32);
    // restart past the end mark: all three bytes read as zero
    add_req(REQ_START,   8'h00, 1'b0, 8'd0,   6'd0);
    add_req(REQ_BIT,     8'h00, 1'b0, 8'd1,   6'd0);
    // push into an empty FIFO without the mark opens a new partition
    add_req(REQ_PUSH,    8'h80, 1'b0, 8'd0,   6'd0);
    add_req(REQ_LITERAL, 8'h00, 1'b0, 8'd0,   6'd20);
    add_req(REQ_PUSH,    8'h3C, 1'b0, 8'd0,   6'd0);
    add_req(REQ_LITERAL, 8'h00, 1'b0, 8'd0,   6'd20);
    add_req(REQ_LITERAL, 8'h00, 1'b0, 8'd0,   6'd1);

    first = 1'b1;
    while (pending_reqs.size() < ItemTarget) begin
      pick  = first ? 16 : $urandom_range(0, 19);
      first = 1'b0;
      if (pick < 14) begin
        // well-formed partition with pushes interleaved into the decodes
        len = $urandom_range(3, 16);
        for (int i = 0; i < len; i++) push_rand(i == len - 1 && $urandom_range(0, 3) == 0);
        add_req(REQ_START, 8'($urandom), 1'($urandom), 8'($urandom), 6'($urandom));
        steps = $urandom_range(10, 40);
        for (int i = 0; i < steps; i++) begin
          if ($urandom_range(0, 9) < 3) push_rand($urandom_range(0, 15) == 0);
          else decode_rand();
        end
      end else if (pick < 16) begin
        for (int i = 0; i < 10; i++)
          add_req(req_type_e'(2'($urandom)), 8'($urandom), 1'($urandom), 8'($urandom),
                  6'($urandom));
      end else if (pick < 18) begin
        // overrun the FIFO
        for (int i = 0; i < FifoDepth + 2; i++) push_rand(1'b0);
        for (int i = 0; i < 3; i++) decode_rand();
      end else begin
        // short partition, then decode well past its end
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_rand(i == len - 1);
        add_req(REQ_START, 8'($urandom), 1'($urandom), 8'($urandom), 6'($urandom));
        for (int i = 0; i < 10; i++) decode_rand();
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.req_type     <= REQ_PUSH;
      req_if.data_byte    <= 8'd0;
      req_if.last_byte    <= 1'b0;
      req_if.probability  <= 8'd0;
      req_if.literal_bits <= 6'd0;
    end else if (!(req_if.valid && !req_if.ready)) begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(decode_request(pending_reqs.pop_front()));
        reqs_sent++;
        send_gap = send_burst ? 0 : $urandom_range(0, 11);
        if (reqs_sent % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
        if (reqs_sent == DrainAt) drain_wait = 1'b1;
      end
      if (drain_wait && expected_rsps.size() != 0) begin
        req_if.valid <= 1'b0;
      end else if (send_gap > 0) begin
        drain_wait = 1'b0;
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        drain_wait = 1'b0;
        req_if.valid        <= 1'b1;
        req_if.req_type     <= pending_reqs[0].kind;
        req_if.data_byte    <= pending_reqs[0].data;
        req_if.last_byte    <= pending_reqs[0].last;
        req_if.probability  <= pending_reqs[0].prob;
        req_if.literal_bits <= pending_reqs[0].nbits;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsps_seen++;
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction: expected none, got value %h status %0d",
                   $time, rsp_if.value, rsp_if.status);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.value !== want.value) begin
            errors++;
            $display("%0t: value mismatch: expected %h, got %h",
                     $time, want.value, rsp_if.value);
          end
          if (rsp_if.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, rsp_if.status);
          end
        end
        recv_stall = recv_burst ? 0 : $urandom_range(0, 11);
        if (rsps_seen % 80 == 0) recv_burst = ($urandom_range(0, 3) == 0);
        if (rsps_seen == HoldAt) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: stop if no transaction moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

endmodule
